FILE: hw/rtl/sca_pkg.sv
// ---------------------------------------------------------------------------
// sca_pkg: shared types and constants for the size-class slab allocator
// Pool geometry, status codes and link formats used by every module.
// ---------------------------------------------------------------------------
package sca_pkg;

  localparam int PAGE_WORDS  = 1024;
  localparam int NUM_PAGES   = 64;
  localparam int NUM_BUCKETS = 257;
  localparam int WORD_BYTES  = 4;

  localparam int POOL_WORDS  = NUM_PAGES * PAGE_WORDS;
  localparam int ADDR_W      = $clog2(POOL_WORDS);
  localparam int PG_W        = $clog2(NUM_PAGES);
  localparam int OFF_W       = $clog2(PAGE_WORDS);
  localparam int BKT_W       = $clog2(NUM_BUCKETS);
  localparam int CNT_W       = $clog2(PAGE_WORDS) + 1;
  localparam int WALK_W      = $clog2(POOL_WORDS + 2);
  localparam int SIZE_W      = 32;
  localparam int MAX_SMALL   = (NUM_BUCKETS - 1) * WORD_BYTES;

  localparam int IN_DATA_W   = SIZE_W + 16;
  localparam int OUT_FIELD_W = 16 + 2 + 1;
  localparam int OUT_DATA_W  = ((OUT_FIELD_W + 7) / 8) * 8;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_TOO_LARGE = 2'd1,
    ST_NO_PAGES  = 2'd2,
    ST_BAD_SIZE  = 2'd3
  } status_t;

  typedef enum logic {
    REQ_ALLOC = 1'b0,
    REQ_FREE  = 1'b1
  } req_t;

  typedef struct packed {
    status_t            status;
    logic [BKT_W-1:0]   bucket;
  } size_class_t;

  typedef struct packed {
    logic               vld;
    logic [ADDR_W-1:0]  addr;
  } link_t;

  typedef struct packed {
    logic               vld;
    logic [PG_W-1:0]    page;
  } plink_t;

endpackage

FILE: hw/rtl/size_class_slab_allocator.sv
// ---------------------------------------------------------------------------
// size_class_slab_allocator: slab allocator with word-sized size buckets
// Serves alloc and free items over a pool of 64 pages of 1024 words.
// ---------------------------------------------------------------------------
// Usage: one item at a time. An alloc that hits a non-empty bucket steps
// through S_HEAD, S_POP_RD, S_POP and S_DONE; one that needs a fresh page
// first carves it in S_CARVE, one slot link write per cycle for each slot
// that fits from word 1. A free steps through S_HEAD and S_DONE; when it
// empties its page it walks the bucket's slot list (a slot-link memory read,
// then the unlink write, per entry), bounded by the pool size plus one, then
// returns the page. A finished result waits in the output register while the
// next item is accepted. No clearing pass after reset: bucket heads and page
// links carry valid flops, slot links are only read after being written, and
// page counts likewise, but for a free into a page that was never carved.
module size_class_slab_allocator (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [31:0] size_bytes, [47:32] slot_address
  input  logic [sca_pkg::IN_DATA_W-1:0]     in_tdata,
  // [0] req_type
  input  logic                              in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [15:0] granted_address, [17:16] status, [18] page_released, rest zero
  output logic [sca_pkg::OUT_DATA_W-1:0]    out_tdata
);
  import sca_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_HEAD   = 8'b0000_0010,
    S_CARVE  = 8'b0000_0100,
    S_POP_RD = 8'b0000_1000,
    S_POP    = 8'b0001_0000,
    S_UL_RD  = 8'b0010_0000,
    S_UL     = 8'b0100_0000,
    S_DONE   = 8'b1000_0000
  } state_t;

  localparam int SUM_W = OFF_W + 2;

  // control and item state
  state_t            state_r, state_nxt;
  req_t              req_r, req_nxt;
  logic [BKT_W-1:0]  bkt_r, bkt_nxt;
  status_t           status_r, status_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  link_t             cur_r, cur_nxt;
  logic [ADDR_W-1:0] prev_r, prev_nxt;
  logic              have_prev_r, have_prev_nxt;
  logic [PG_W-1:0]   page_r, page_nxt;
  logic [OFF_W-1:0]  off_r, off_nxt;
  logic [WALK_W-1:0] walk_r, walk_nxt;
  plink_t            fph_r, fph_nxt;
  logic              released_r, released_nxt;
  logic [ADDR_W-1:0] granted_r, granted_nxt;

  // output register
  logic                  out_vld_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic                  out_load;

  // memories and their ports
  logic [ADDR_W-1:0] bh_mem [NUM_BUCKETS];
  logic [NUM_BUCKETS-1:0] bh_vld_r;
  logic [ADDR_W-1:0] bh_rdata_r;
  logic              bh_we;
  link_t             bh_wdata;

  link_t             sl_mem [POOL_WORDS];
  link_t             sl_rdata_r;
  logic              sl_we;
  logic [ADDR_W-1:0] sl_waddr;
  link_t             sl_wdata;

  logic [CNT_W-1:0]  pu_mem [NUM_PAGES];
  logic [CNT_W-1:0]  pu_rdata_r;
  logic [PG_W-1:0]   pu_raddr;
  logic              pu_we;
  logic [PG_W-1:0]   pu_waddr;
  logic [CNT_W-1:0]  pu_wdata;

  plink_t            pl_mem [NUM_PAGES];
  logic [NUM_PAGES-1:0] pl_vld_r;
  plink_t            pl_rdata_r;
  logic              pl_we;

  // decoded input item
  size_class_t       in_cls;
  logic [ADDR_W-1:0] in_addr;
  logic              in_fire;

  // scratch
  link_t             head;
  plink_t            pl_link;
  logic [SUM_W-1:0]  off_sum, off_sum2;
  logic [ADDR_W-1:0] carve_addr;

  sca_size_dec u_size_dec (
    .size_bytes (in_tdata[SIZE_W-1:0]),
    .cls        (in_cls)
  );

  assign in_addr   = in_tdata[SIZE_W +: ADDR_W];
  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

  // bucket head with its valid flop
  assign head.vld  = bh_vld_r[bkt_r];
  assign head.addr = bh_rdata_r;

  // next link of the head page; an untouched entry reads as its reset chain
  always_comb begin
    if (pl_vld_r[fph_r.page]) begin
      pl_link = pl_rdata_r;
    end else if (int'(fph_r.page) + 1 < NUM_PAGES) begin
      pl_link.vld  = 1'b1;
      pl_link.page = fph_r.page + PG_W'(1);
    end else begin
      pl_link = '0;
    end
  end

  assign off_sum    = SUM_W'(off_r) + SUM_W'(bkt_r);
  assign off_sum2   = off_sum + SUM_W'(bkt_r);
  assign carve_addr = {page_r, off_r};

  assign pu_raddr = (state_r == S_IDLE) ? in_addr[ADDR_W-1 -: PG_W]
                                        : cur_r.addr[ADDR_W-1 -: PG_W];

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    bkt_nxt       = bkt_r;
    status_nxt    = status_r;
    addr_nxt      = addr_r;
    cur_nxt       = cur_r;
    prev_nxt      = prev_r;
    have_prev_nxt = have_prev_r;
    page_nxt      = page_r;
    off_nxt       = off_r;
    walk_nxt      = walk_r;
    fph_nxt       = fph_r;
    released_nxt  = released_r;
    granted_nxt   = granted_r;
    out_load      = 1'b0;
    bh_we         = 1'b0;
    bh_wdata      = '0;
    sl_we         = 1'b0;
    sl_waddr      = cur_r.addr;
    sl_wdata      = '0;
    pu_we         = 1'b0;
    pu_waddr      = cur_r.addr[ADDR_W-1 -: PG_W];
    pu_wdata      = '0;
    pl_we         = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          req_nxt      = req_t'(in_tuser);
          bkt_nxt      = in_cls.bucket;
          status_nxt   = in_cls.status;
          addr_nxt     = in_addr;
          released_nxt = 1'b0;
          granted_nxt  = '0;
          state_nxt    = S_HEAD;
        end
      end

      S_HEAD: begin
        if (status_r != ST_OK) begin
          state_nxt = S_DONE;
        end else if (req_r == REQ_ALLOC) begin
          if (head.vld) begin
            cur_nxt   = head;
            state_nxt = S_POP_RD;
          end else if (!fph_r.vld) begin
            status_nxt = ST_NO_PAGES;
            state_nxt  = S_DONE;
          end else begin
            // take the head page, zero its count, carve from word 1
            fph_nxt   = pl_link;
            pu_we     = 1'b1;
            pu_waddr  = fph_r.page;
            pu_wdata  = '0;
            page_nxt  = fph_r.page;
            off_nxt   = OFF_W'(1);
            cur_nxt   = head;
            state_nxt = S_CARVE;
          end
        end else begin
          if (pu_rdata_r == '0) begin
            state_nxt = S_DONE;
          end else begin
            // push the slot, drop the page count
            sl_we    = 1'b1;
            sl_waddr = addr_r;
            sl_wdata = head;
            bh_we    = 1'b1;
            bh_wdata = '{vld: 1'b1, addr: addr_r};
            pu_we    = 1'b1;
            pu_waddr = addr_r[ADDR_W-1 -: PG_W];
            pu_wdata = pu_rdata_r - CNT_W'(1);
            if (pu_rdata_r == CNT_W'(1)) begin
              released_nxt  = 1'b1;
              cur_nxt       = '{vld: 1'b1, addr: addr_r};
              have_prev_nxt = 1'b0;
              walk_nxt      = '0;
              page_nxt      = addr_r[ADDR_W-1 -: PG_W];
              state_nxt     = S_UL_RD;
            end else begin
              state_nxt = S_DONE;
            end
          end
        end
      end

      S_CARVE: begin
        sl_we    = 1'b1;
        sl_waddr = carve_addr;
        sl_wdata = cur_r;
        cur_nxt  = '{vld: 1'b1, addr: carve_addr};
        off_nxt  = off_sum[OFF_W-1:0];
        if (off_sum2 > SUM_W'(PAGE_WORDS)) begin
          state_nxt = S_POP_RD;
        end
      end

      S_POP_RD: begin
        state_nxt = S_POP;
      end

      S_POP: begin
        bh_we       = 1'b1;
        bh_wdata    = sl_rdata_r;
        pu_we       = 1'b1;
        pu_wdata    = pu_rdata_r + CNT_W'(1);
        granted_nxt = cur_r.addr;
        state_nxt   = S_DONE;
      end

      S_UL_RD: begin
        if (cur_r.vld && (int'(walk_r) <= POOL_WORDS)) begin
          state_nxt = S_UL;
        end else begin
          // return the page to the free list
          pl_we     = 1'b1;
          fph_nxt   = '{vld: 1'b1, page: page_r};
          state_nxt = S_DONE;
        end
      end

      S_UL: begin
        if (cur_r.addr[ADDR_W-1 -: PG_W] == page_r) begin
          if (have_prev_r) begin
            sl_we    = 1'b1;
            sl_waddr = prev_r;
            sl_wdata = sl_rdata_r;
          end else begin
            bh_we    = 1'b1;
            bh_wdata = sl_rdata_r;
          end
        end else begin
          prev_nxt      = cur_r.addr;
          have_prev_nxt = 1'b1;
        end
        cur_nxt   = sl_rdata_r;
        walk_nxt  = walk_r + WALK_W'(1);
        state_nxt = S_UL_RD;
      end

      S_DONE: begin
        if (!out_vld_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      fph_r     <= '{vld: 1'b1, page: '0};
      out_vld_r <= 1'b0;
      bh_vld_r  <= '0;
      pl_vld_r  <= '0;
    end else begin
      state_r <= state_nxt;
      fph_r   <= fph_nxt;
      if (out_load) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
      if (bh_we) begin
        bh_vld_r[bkt_r] <= bh_wdata.vld;
      end
      if (pl_we) begin
        pl_vld_r[page_r] <= 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    req_r       <= req_nxt;
    bkt_r       <= bkt_nxt;
    status_r    <= status_nxt;
    addr_r      <= addr_nxt;
    cur_r       <= cur_nxt;
    prev_r      <= prev_nxt;
    have_prev_r <= have_prev_nxt;
    page_r      <= page_nxt;
    off_r       <= off_nxt;
    walk_r      <= walk_nxt;
    released_r  <= released_nxt;
    granted_r   <= granted_nxt;
    if (out_load) begin
      out_data_r <= OUT_DATA_W'({released_r, status_r, 16'(granted_r)});
    end
  end

  // bucket head memory
  always_ff @(posedge clk) begin
    if (bh_we) begin
      bh_mem[bkt_r] <= bh_wdata.addr;
    end
    bh_rdata_r <= bh_mem[in_cls.bucket];
  end

  // slot link memory
  always_ff @(posedge clk) begin
    if (sl_we) begin
      sl_mem[sl_waddr] <= sl_wdata;
    end
    sl_rdata_r <= sl_mem[cur_r.addr];
  end

  // page use count memory
  always_ff @(posedge clk) begin
    if (pu_we) begin
      pu_mem[pu_waddr] <= pu_wdata;
    end
    pu_rdata_r <= pu_mem[pu_raddr];
  end

  // page link memory
  always_ff @(posedge clk) begin
    if (pl_we) begin
      pl_mem[page_r] <= fph_r;
    end
    pl_rdata_r <= pl_mem[fph_r.page];
  end

endmodule

FILE: hw/rtl/sca_size_dec.sv
// ---------------------------------------------------------------------------
// sca_size_dec: size class decoder
// Rounds a byte size up to whole words and checks it against the buckets.
// ---------------------------------------------------------------------------
module sca_size_dec (
  input  logic [sca_pkg::SIZE_W-1:0] size_bytes,
  output sca_pkg::size_class_t       cls
);
  import sca_pkg::*;

  localparam int RND_W = $clog2(MAX_SMALL + WORD_BYTES) + 1;

  logic [RND_W-1:0] rounded;
  logic [RND_W-1:0] words;

  always_comb begin
    rounded    = RND_W'(size_bytes) + RND_W'(WORD_BYTES - 1);
    words      = RND_W'(rounded / WORD_BYTES);
    cls.bucket = words[BKT_W-1:0];
    if (size_bytes == '0) begin
      cls.status = ST_BAD_SIZE;
    end else if (size_bytes > SIZE_W'(MAX_SMALL)) begin
      cls.status = ST_TOO_LARGE;
    end else if ((int'(words) + 1 > PAGE_WORDS) || (int'(words) >= NUM_BUCKETS)) begin
      cls.status = ST_TOO_LARGE;
    end else begin
      cls.status = ST_OK;
    end
  end

endmodule

FILE: sim/tb_size_class_slab_allocator.sv
// ---------------------------------------------------------------------------
// tb_size_class_slab_allocator: self-checking bench for the slab allocator
// Drives alloc and free items over the input stream with random idling and
// back-pressure. It mirrors the bucket lists, page counts and free page list
// to work out each expected grant, and checks every result field by field.
// ---------------------------------------------------------------------------
module tb_size_class_slab_allocator;
  timeunit 1ns;
  timeprecision 1ps;
  import sca_pkg::*;

  typedef struct {
    logic [15:0] granted;
    status_t     status;
    logic        released;
  } grant_t;

  // Mirror of the allocator state. Links carry the valid flag in bit 16,
  // page links in bit 6.
  class alloc_tracker;
    logic [16:0] bucket_head [NUM_BUCKETS];
    logic [16:0] slot_next [POOL_WORDS];
    int unsigned page_count [NUM_PAGES];
    logic [6:0]  page_next [NUM_PAGES];
    logic [6:0]  free_pages;
    grant_t      pending_grants[$];
    int          errors;

    function new();
      foreach (bucket_head[i]) bucket_head[i] = '0;
      foreach (slot_next[i]) slot_next[i] = '0;
      foreach (page_count[i]) page_count[i] = 0;
      foreach (page_next[i])
        page_next[i] = (i + 1 < NUM_PAGES) ? {1'b1, 6'(i + 1)} : 7'd0;
      free_pages = 7'b100_0000;
      errors = 0;
    endfunction

    function void push_slot(int unsigned b, int unsigned a);
      slot_next[a] = bucket_head[b];
      bucket_head[b] = {1'b1, 16'(a)};
    endfunction

    // Take the head free page and thread its slots onto bucket b.
    function void carve(int unsigned b);
      int unsigned pg;
      pg = free_pages[5:0];
      free_pages = page_next[pg];
      page_count[pg] = 0;
      for (int unsigned off = 1; off + b <= PAGE_WORDS; off += b)
        push_slot(b, pg * PAGE_WORDS + off);
    endfunction

    // Drop every slot of page pg from bucket b; bounded against loops.
    function void unlink(int unsigned b, int unsigned pg);
      logic [16:0] cur;
      logic [16:0] nxt;
      int unsigned a, prev;
      bit have_prev;
      cur = bucket_head[b];
      prev = 0;
      have_prev = 0;
      for (int unsigned n = 0; cur[16] && n <= POOL_WORDS; n++) begin
        a = cur[15:0];
        nxt = slot_next[a];
        if (a / PAGE_WORDS == pg) begin
          if (have_prev) slot_next[prev] = nxt;
          else bucket_head[b] = nxt;
        end else begin
          prev = a;
          have_prev = 1;
        end
        cur = nxt;
      end
    endfunction

    function grant_t note_request(req_t req, logic [31:0] size, logic [15:0] addr);
      grant_t g;
      int unsigned b, a, pg;
      logic [16:0] head;
      g.granted = '0;
      g.status = ST_OK;
      g.released = 1'b0;
      b = 0;
      if (size == 0) g.status = ST_BAD_SIZE;
      else if (size > MAX_SMALL) g.status = ST_TOO_LARGE;
      else begin
        b = (size + WORD_BYTES - 1) / WORD_BYTES;
        if (b + 1 > PAGE_WORDS || b >= NUM_BUCKETS) g.status = ST_TOO_LARGE;
      end
      if (g.status == ST_OK && req == REQ_ALLOC) begin
        head = bucket_head[b];
        if (!head[16]) begin
          if (!free_pages[6]) g.status = ST_NO_PAGES;
          else begin
            carve(b);
            head = bucket_head[b];
          end
        end
        if (g.status == ST_OK && head[16]) begin
          a = head[15:0];
          bucket_head[b] = slot_next[a];
          page_count[a / PAGE_WORDS]++;
          g.granted = 16'(a);
        end else if (g.status == ST_OK) g.status = ST_NO_PAGES;
      end else if (g.status == ST_OK && req == REQ_FREE) begin
        pg = addr / PAGE_WORDS;
        if (page_count[pg] != 0) begin
          push_slot(b, addr);
          page_count[pg]--;
          if (page_count[pg] == 0) begin
            unlink(b, pg);
            page_next[pg] = free_pages;
            free_pages = {1'b1, 6'(pg)};
            g.released = 1'b1;
          end
        end
      end
      pending_grants.push_back(g);
      return g;
    endfunction

    function void check_grant(logic [OUT_DATA_W-1:0] data);
      grant_t g;
      if (pending_grants.size() == 0) begin
        $error("result with no item outstanding: %h", data);
        errors++;
        return;
      end
      g = pending_grants.pop_front();
      if (data[15:0] !== g.granted) begin
        $error("granted_address: expected %0d actual %0d", g.granted, data[15:0]);
        errors++;
      end
      if (data[17:16] !== g.status) begin
        $error("status: expected %0d actual %0d", g.status, data[17:16]);
        errors++;
      end
      if (data[18] !== g.released) begin
        $error("page_released: expected %0d actual %0d", g.released, data[18]);
        errors++;
      end
    endfunction

    function int outstanding();
      return pending_grants.size();
    endfunction
  endclass

  typedef struct {
    logic [15:0] addr;
    int unsigned bucket;
  } live_slot_t;

  logic clk = 0;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata;
  logic in_tuser;
  logic out_tvalid;
  logic out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;

  alloc_tracker tracker = new();
  live_slot_t live_slots[$];
  bit page_taken [NUM_PAGES];
  int send_idle_pct;
  int recv_idle_pct;
  int hold_cycles;
  grant_t last_grant;

  // bucket 250 is sacrificed to the duplicate-free case and kept out of random
  localparam int DEAD_BUCKET = 250;

  size_class_slab_allocator DUT (.*);

  always #10 clk = ~clk;

  // Receiver: random stalls, or a long hold-off while hold_cycles runs down.
  initial begin
    out_tready = 0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_tready = 0;
        hold_cycles--;
      end else out_tready = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) tracker.check_grant(out_tdata);
  end

  // Offer one item from a falling edge; return at the falling edge after it
  // is taken, leaving tvalid high for the next call to decide.
  task automatic send_item(req_t req, logic [31:0] size, logic [15:0] addr);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid = 0;
      @(negedge clk);
    end
    in_tvalid = 1;
    in_tuser = req;
    in_tdata = {addr, size};
    do @(posedge clk); while (!in_tready);
    last_grant = tracker.note_request(req, size, addr);
    if (req == REQ_ALLOC && last_grant.status == ST_OK)
      page_taken[last_grant.granted / PAGE_WORDS] = 1;
    @(negedge clk);
  endtask

  task automatic drain();
    in_tvalid = 0;
    while (tracker.outstanding() != 0) @(negedge clk);
  endtask

  function automatic logic [31:0] size_in_bucket(int unsigned b);
    return $urandom_range(b * WORD_BYTES, (b - 1) * WORD_BYTES + 1);
  endfunction

  task automatic alloc_random();
    int unsigned b;
    // mostly wide slots: cheap carving, and page pressure builds fast
    if ($urandom_range(99) < 85) b = $urandom_range(NUM_BUCKETS - 1, 129);
    else b = $urandom_range(128, 1);
    if (b == DEAD_BUCKET) b++;
    send_item(REQ_ALLOC, size_in_bucket(b), 16'd0);
    if (last_grant.status == ST_OK) live_slots.push_back('{last_grant.granted, b});
  endtask

  task automatic free_random();
    int idx;
    idx = $urandom_range(live_slots.size() - 1);
    send_item(REQ_FREE, size_in_bucket(live_slots[idx].bucket), live_slots[idx].addr);
    live_slots.delete(idx);
  endtask

  task automatic noise_item();
    logic [15:0] a;
    int unsigned b;
    case ($urandom_range(2))
      0: send_item(req_t'($urandom_range(1)), 32'd0, 16'($urandom));
      1: send_item(req_t'($urandom_range(1)), $urandom | 32'h401, 16'($urandom));
      default: begin
        // stray free at any address of a page that was handed out once
        a = $urandom;
        if (page_taken[a / PAGE_WORDS]) begin
          b = $urandom_range(NUM_BUCKETS - 1, 1);
          if (b == DEAD_BUCKET) b--;
          send_item(REQ_FREE, size_in_bucket(b), a);
        end
      end
    endcase
  endtask

  task automatic random_phase(int items);
    int alloc_pct;
    for (int i = 0; i < items; i++) begin
      if (i % 40 == 0) alloc_pct = (i % 80 == 0) ? 75 : 30;
      if ($urandom_range(99) < 6) noise_item();
      else if ($urandom_range(99) < alloc_pct || live_slots.size() == 0) alloc_random();
      else free_random();
    end
  endtask

  initial begin
    logic [15:0] one_a, one_b, two_a, wide_a, dup_a;
    rst_n = 0;
    in_tvalid = 0;
    in_tuser = 0;
    in_tdata = '0;
    hold_cycles = 0;
    send_idle_pct = 21;
    recv_idle_pct = 46;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // Directed: fresh page carving, the ok, too-large and bad-size statuses, release and the odd frees.
    send_item(REQ_ALLOC, 32'd1, 16'd0);            one_a = last_grant.granted;
    send_item(REQ_ALLOC, 32'd4, 16'd0);            one_b = last_grant.granted;
    send_item(REQ_ALLOC, 32'd5, 16'd0);            two_a = last_grant.granted;
    send_item(REQ_ALLOC, 32'd1024, 16'd0);         wide_a = last_grant.granted;
    send_item(REQ_ALLOC, 32'd1025, 16'd0);
    send_item(REQ_ALLOC, 32'hFFFF_FFFF, 16'hFFFF);
    send_item(REQ_ALLOC, 32'd0, 16'd0);
    send_item(REQ_FREE, 32'd0, one_a);
    send_item(REQ_FREE, 32'd2000, one_a);
    send_item(REQ_FREE, 32'h8000_0000, one_a);
    send_item(REQ_FREE, 32'd1024, wide_a);         // empties its page
    send_item(REQ_FREE, 32'd1024, wide_a);         // page count now zero: dropped
    send_item(REQ_ALLOC, 32'd1000, 16'd0);         dup_a = last_grant.granted;
    send_item(REQ_ALLOC, 32'd1000, 16'd0);
    send_item(REQ_FREE, 32'd1000, dup_a);
    send_item(REQ_FREE, 32'd1000, dup_a);          // duplicate: loops the list
    send_item(REQ_FREE, 32'd8, 16'd0);             // word 0 of a page: misaligned
    send_item(REQ_FREE, 32'd1, one_a);             // releases the one-word page
    send_item(REQ_FREE, 32'd4, one_b);             // into the released page: dropped
    send_item(REQ_FREE, 32'd5, two_a);             // releases the two-word page
    drain();

    random_phase(190);
    drain();

    send_idle_pct = 46;
    recv_idle_pct = 21;
    random_phase(190);
    drain();

    // No idling; start with a long receiver hold-off so the input stalls.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_cycles = 400;
    random_phase(190);
    drain();

    repeat (50) @(posedge clk);
    if (tracker.errors == 0 && tracker.outstanding() == 0)
      $display("tb_size_class_slab_allocator OK");
    else
      $display("tb_size_class_slab_allocator NOT OK");
    $finish;
  end

  initial begin
    #8s;
    $display("tb_size_class_slab_allocator NOT OK");
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/sca_pkg.sv
hw/rtl/sca_size_dec.sv
hw/rtl/size_class_slab_allocator.sv
sim/tb_size_class_slab_allocator.sv
